>>> hw/rtl/srq_pkg.sv
// srq_pkg: sizes, opcodes, status codes and controller command type
// for the sorted request queue. No dependencies.
package srq_pkg;

   localparam int DEPTH      = 16;
   localparam int ID_BITS    = 8;
   localparam int STAMP_BITS = 32;
   localparam int IDX_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS   = $clog2(DEPTH + 1);

   localparam int OP_W  = 2;
   localparam int ST_W  = 2;
   localparam int POS_W = 4;
   localparam int TS_W  = 32;
   localparam int CNT_W = 5;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [ST_W-1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic capture;
      logic compare;
      logic apply;
   } cmd_type;

endpackage

>>> hw/rtl/sorted_request_queue.sv
// sorted_request_queue: top level, controller plus datapath.
// Depends on srq_pkg, srq_ctrl, srq_datapath.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | opcode, process_id, timestamp, going_up
//  rsp     | out       | rsp_valid/stall   | status, position, found_timestamp,
//          |           |                   | found_going_up, entry_count
//
// Each transaction goes through capture, parallel compare across all
// cells, then shift/update and result load. The next request is taken
// while a result is still held; the update stage waits while rsp_stall holds
// a previous result. Synchronous reset empties the queue; entry contents
// are not cleared.
module sorted_request_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [srq_pkg::OP_W-1:0]         req_opcode,
   input  logic [srq_pkg::ID_BITS-1:0]      req_process_id,
   input  logic [srq_pkg::STAMP_BITS-1:0]   req_timestamp,
   input  logic                             req_going_up,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [srq_pkg::ST_W-1:0]         rsp_status,
   output logic [srq_pkg::POS_W-1:0]        rsp_position,
   output logic [srq_pkg::TS_W-1:0]         rsp_found_timestamp,
   output logic                             rsp_found_going_up,
   output logic [srq_pkg::CNT_W-1:0]        rsp_entry_count
);

   srq_pkg::cmd_type cmd;

   srq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   srq_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_opcode          (req_opcode),
      .req_process_id      (req_process_id),
      .req_timestamp       (req_timestamp),
      .req_going_up        (req_going_up),
      .rsp_status          (rsp_status),
      .rsp_position        (rsp_position),
      .rsp_found_timestamp (rsp_found_timestamp),
      .rsp_found_going_up  (rsp_found_going_up),
      .rsp_entry_count     (rsp_entry_count)
   );

endmodule

>>> hw/rtl/srq_ctrl.sv
// srq_ctrl: sequencer for one transaction (capture, compare, apply)
// and the result valid flag. Depends on srq_pkg.
module srq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output srq_pkg::cmd_type cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CMP   = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CMP;
            end
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in    = S_APPLY;
         end
         S_APPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.apply    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/srq_datapath.sv
// srq_datapath: row of sorted entry cells, parallel key/id compare,
// shift-insert and shift-remove, result register. Depends on srq_pkg.
module srq_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  srq_pkg::cmd_type                 cmd,
   input  logic [srq_pkg::OP_W-1:0]         req_opcode,
   input  logic [srq_pkg::ID_BITS-1:0]      req_process_id,
   input  logic [srq_pkg::STAMP_BITS-1:0]   req_timestamp,
   input  logic                             req_going_up,
   output logic [srq_pkg::ST_W-1:0]         rsp_status,
   output logic [srq_pkg::POS_W-1:0]        rsp_position,
   output logic [srq_pkg::TS_W-1:0]         rsp_found_timestamp,
   output logic                             rsp_found_going_up,
   output logic [srq_pkg::CNT_W-1:0]        rsp_entry_count
);

   localparam int N = srq_pkg::DEPTH;

   logic [srq_pkg::OP_W-1:0]       op_ff;
   logic [srq_pkg::ID_BITS-1:0]    id_ff;
   logic [srq_pkg::STAMP_BITS-1:0] stamp_ff;
   logic                           dir_ff;

   logic [srq_pkg::STAMP_BITS-1:0] cell_stamp_ff [N];
   logic [srq_pkg::STAMP_BITS-1:0] cell_stamp_in [N];
   logic [srq_pkg::ID_BITS-1:0]    cell_id_ff [N];
   logic [srq_pkg::ID_BITS-1:0]    cell_id_in [N];
   logic                           cell_dir_ff [N];
   logic                           cell_dir_in [N];
   logic [srq_pkg::CNT_BITS-1:0]   count_ff, count_in;

   logic [N-1:0] ge_ff, ge_in;
   logic [N-1:0] match_ff, match_in;

   logic [srq_pkg::ST_W-1:0]       status_in;
   logic [srq_pkg::IDX_BITS-1:0]   pos_in;
   logic [srq_pkg::STAMP_BITS-1:0] fts_in;
   logic                           fdir_in;
   logic [srq_pkg::ST_W-1:0]       status_ff;
   logic [srq_pkg::IDX_BITS-1:0]   pos_ff;
   logic [srq_pkg::STAMP_BITS-1:0] fts_ff;
   logic                           fdir_ff;

   // per-cell compares: ge = slot at/after insert point, match = id hit
   always_comb begin
      for (int i = 0; i < N; i++) begin
         ge_in[i] = (srq_pkg::CNT_BITS'(i) >= count_ff) ||
                    (cell_stamp_ff[i] > stamp_ff) ||
                    ((cell_stamp_ff[i] == stamp_ff) && (cell_id_ff[i] > id_ff));
         match_in[i] = (srq_pkg::CNT_BITS'(i) < count_ff) && (cell_id_ff[i] == id_ff);
      end
   end

   logic [N-1:0] first;
   logic [N-1:0] seen;

   always_comb begin
      logic acc;
      acc = 1'b0;
      for (int i = 0; i < N; i++) begin
         first[i] = match_ff[i] && !acc;
         acc      = acc || match_ff[i];
         seen[i]  = acc;
      end
   end

   always_comb begin
      pos_in  = '0;
      fts_in  = '0;
      fdir_in = 1'b0;
      for (int i = 0; i < N; i++) begin
         if (first[i]) begin
            pos_in  = pos_in | srq_pkg::IDX_BITS'(i);
            fts_in  = fts_in | cell_stamp_ff[i];
            fdir_in = fdir_in | cell_dir_ff[i];
         end
      end
   end

   always_comb begin
      status_in = srq_pkg::ST_OK;
      count_in  = count_ff;
      for (int i = 0; i < N; i++) begin
         cell_stamp_in[i] = cell_stamp_ff[i];
         cell_id_in[i]    = cell_id_ff[i];
         cell_dir_in[i]   = cell_dir_ff[i];
      end
      case (op_ff)
         srq_pkg::OP_INSERT: begin
            if (count_ff == srq_pkg::CNT_BITS'(N)) begin
               status_in = srq_pkg::ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
               for (int i = 0; i < N; i++) begin
                  if (i > 0 && ge_ff[(i > 0) ? i - 1 : 0]) begin
                     cell_stamp_in[i] = cell_stamp_ff[(i > 0) ? i - 1 : 0];
                     cell_id_in[i]    = cell_id_ff[(i > 0) ? i - 1 : 0];
                     cell_dir_in[i]   = cell_dir_ff[(i > 0) ? i - 1 : 0];
                  end else if (ge_ff[i]) begin
                     cell_stamp_in[i] = stamp_ff;
                     cell_id_in[i]    = id_ff;
                     cell_dir_in[i]   = dir_ff;
                  end
               end
            end
         end
         srq_pkg::OP_REMOVE, srq_pkg::OP_LOOKUP: begin
            if (count_ff == '0) begin
               status_in = srq_pkg::ST_EMPTY;
            end else if (match_ff == '0) begin
               status_in = srq_pkg::ST_NOT_FOUND;
            end else if (op_ff == srq_pkg::OP_REMOVE) begin
               count_in = count_ff - 1'b1;
               for (int i = 0; i < N - 1; i++) begin
                  if (seen[i]) begin
                     cell_stamp_in[i] = cell_stamp_ff[i + 1];
                     cell_id_in[i]    = cell_id_ff[i + 1];
                     cell_dir_in[i]   = cell_dir_ff[i + 1];
                  end
               end
            end
         end
         default: begin
            status_in = srq_pkg::ST_OK;
         end
      endcase
   end

   logic report;
   assign report = (op_ff == srq_pkg::OP_REMOVE || op_ff == srq_pkg::OP_LOOKUP) &&
                   (count_ff != '0) && (match_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.apply) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         id_ff    <= req_process_id;
         stamp_ff <= req_timestamp;
         dir_ff   <= req_going_up;
      end
      if (cmd.compare) begin
         ge_ff    <= ge_in;
         match_ff <= match_in;
      end
      if (cmd.apply) begin
         for (int i = 0; i < N; i++) begin
            cell_stamp_ff[i] <= cell_stamp_in[i];
            cell_id_ff[i]    <= cell_id_in[i];
            cell_dir_ff[i]   <= cell_dir_in[i];
         end
         status_ff <= status_in;
         pos_ff    <= report ? pos_in : '0;
         fts_ff    <= report ? fts_in : '0;
         fdir_ff   <= report ? fdir_in : 1'b0;
      end
   end

   logic [srq_pkg::CNT_BITS-1:0] count_out_ff;

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         count_out_ff <= count_in;
      end
   end

   assign rsp_status          = status_ff;
   assign rsp_position        = srq_pkg::POS_W'(pos_ff);
   assign rsp_found_timestamp = srq_pkg::TS_W'(fts_ff);
   assign rsp_found_going_up  = fdir_ff;
   assign rsp_entry_count     = srq_pkg::CNT_W'(count_out_ff);

endmodule

>>> hw/rtl/srq_checker.sv
// srq_checker: port-level assertions for sorted_request_queue, bound
// to the top level. Depends on srq_pkg.
module srq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic [srq_pkg::OP_W-1:0]         req_opcode,
   input logic [srq_pkg::ID_BITS-1:0]      req_process_id,
   input logic [srq_pkg::STAMP_BITS-1:0]   req_timestamp,
   input logic                             req_going_up,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [srq_pkg::ST_W-1:0]         rsp_status,
   input logic [srq_pkg::POS_W-1:0]        rsp_position,
   input logic [srq_pkg::TS_W-1:0]         rsp_found_timestamp,
   input logic                             rsp_found_going_up,
   input logic [srq_pkg::CNT_W-1:0]        rsp_entry_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_entry_count) && $stable(rsp_found_timestamp))
      else $error("stalled response changed");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == srq_pkg::ST_FULL |->
      rsp_entry_count == srq_pkg::CNT_W'(srq_pkg::DEPTH))
      else $error("full status with queue not full");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == srq_pkg::ST_EMPTY |-> rsp_entry_count == '0)
      else $error("empty status with entries held");

   a_pos_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_position != '0 || rsp_found_going_up) |->
      rsp_status == srq_pkg::ST_OK)
      else $error("found fields set on failed transaction");

   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= srq_pkg::CNT_W'(srq_pkg::DEPTH))
      else $error("entry count beyond depth");

endmodule

bind sorted_request_queue srq_checker u_srq_checker (.*);

>>> bench/tb_sorted_request_queue.sv
// tb_sorted_request_queue: self-checking bench for the sorted request queue.
// Random and directed insert/remove/lookup traffic is checked against a built-in
// sorted-queue predictor. Depends on srq_pkg and sorted_request_queue.
module tb_sorted_request_queue;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [srq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 640;

   typedef struct packed {
      logic [srq_pkg::OP_W-1:0]       opcode;
      logic [srq_pkg::ID_BITS-1:0]    process_id;
      logic [srq_pkg::STAMP_BITS-1:0] timestamp;
      logic                           going_up;
   } srq_req_type;

   typedef struct packed {
      logic [srq_pkg::ST_W-1:0]  status;
      logic [srq_pkg::POS_W-1:0] position;
      logic [srq_pkg::TS_W-1:0]  found_timestamp;
      logic                      found_going_up;
      logic [srq_pkg::CNT_W-1:0] entry_count;
   } srq_rsp_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [srq_pkg::OP_W-1:0]       req_opcode = '0;
   logic [srq_pkg::ID_BITS-1:0]    req_process_id = '0;
   logic [srq_pkg::STAMP_BITS-1:0] req_timestamp = '0;
   logic                           req_going_up = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [srq_pkg::ST_W-1:0]       rsp_status;
   logic [srq_pkg::POS_W-1:0]      rsp_position;
   logic [srq_pkg::TS_W-1:0]       rsp_found_timestamp;
   logic                           rsp_found_going_up;
   logic [srq_pkg::CNT_W-1:0]      rsp_entry_count;

   sorted_request_queue u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_process_id      (req_process_id),
      .req_timestamp       (req_timestamp),
      .req_going_up        (req_going_up),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_position        (rsp_position),
      .rsp_found_timestamp (rsp_found_timestamp),
      .rsp_found_going_up  (rsp_found_going_up),
      .rsp_entry_count     (rsp_entry_count)
   );

   srq_req_type pending_reqs[$];
   srq_rsp_type expected_rsps[$];
   srq_req_type sent_req;
   int          send_idle_pct = 14;
   int          recv_idle_pct = 88;
   int          fail_count = 0;

   // predictor state
   logic [srq_pkg::STAMP_BITS-1:0] model_stamp [srq_pkg::DEPTH];
   logic [srq_pkg::ID_BITS-1:0]    model_id    [srq_pkg::DEPTH];
   logic                           model_dir   [srq_pkg::DEPTH];
   int                             model_held = 0;

   // generator-side view of which ids are held
   logic [srq_pkg::ID_BITS-1:0] held_ids[$];

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic predict_queue_op(input srq_req_type r);
      srq_rsp_type e;
      int          p;
      int          i;
      e = '0;
      e.status = srq_pkg::ST_OK;
      case (r.opcode)
         srq_pkg::OP_INSERT: begin
            if (model_held >= srq_pkg::DEPTH) begin
               e.status = srq_pkg::ST_FULL;
            end else begin
               p = 0;
               while (p < model_held &&
                      !((model_stamp[p] > r.timestamp) ||
                        (model_stamp[p] == r.timestamp && model_id[p] > r.process_id)))
                  p++;
               for (i = model_held; i > p; i--) begin
                  model_stamp[i] = model_stamp[i-1];
                  model_id[i]    = model_id[i-1];
                  model_dir[i]   = model_dir[i-1];
               end
               model_stamp[p] = r.timestamp;
               model_id[p]    = r.process_id;
               model_dir[p]   = r.going_up;
               model_held++;
            end
         end
         srq_pkg::OP_REMOVE, srq_pkg::OP_LOOKUP: begin
            if (model_held == 0) begin
               e.status = srq_pkg::ST_EMPTY;
            end else begin
               p = 0;
               while (p < model_held && model_id[p] != r.process_id)
                  p++;
               if (p >= model_held) begin
                  e.status = srq_pkg::ST_NOT_FOUND;
               end else begin
                  e.position        = p[srq_pkg::POS_W-1:0];
                  e.found_timestamp = model_stamp[p];
                  e.found_going_up  = model_dir[p];
                  if (r.opcode == srq_pkg::OP_REMOVE) begin
                     for (i = p; i + 1 < model_held; i++) begin
                        model_stamp[i] = model_stamp[i+1];
                        model_id[i]    = model_id[i+1];
                        model_dir[i]   = model_dir[i+1];
                     end
                     model_held--;
                  end
               end
            end
         end
         default: ;
      endcase
      e.entry_count = model_held[srq_pkg::CNT_W-1:0];
      expected_rsps.push_back(e);
   endtask

   task automatic queue_request(input logic [srq_pkg::OP_W-1:0] op,
                                input logic [srq_pkg::ID_BITS-1:0] id,
                                input logic [srq_pkg::STAMP_BITS-1:0] ts,
                                input logic dir);
      srq_req_type r;
      int          k;
      r.opcode     = op;
      r.process_id = id;
      r.timestamp  = ts;
      r.going_up   = dir;
      pending_reqs.push_back(r);
      if (op == srq_pkg::OP_INSERT && held_ids.size() < srq_pkg::DEPTH) begin
         held_ids.push_back(id);
      end else if (op == srq_pkg::OP_REMOVE) begin
         for (k = 0; k < held_ids.size(); k++) begin
            if (held_ids[k] == id) begin
               held_ids.delete(k);
               break;
            end
         end
      end
   endtask

   task automatic random_phase(input int count);
      int                             n;
      int                             mode_left;
      bit                             filling;
      int                             pick;
      int                             ins_pct;
      logic [srq_pkg::ID_BITS-1:0]    id;
      logic [srq_pkg::STAMP_BITS-1:0] ts;
      n = 0;
      mode_left = 0;
      filling = 1'b1;
      while (n < count) begin
         if (mode_left == 0) begin
            filling = ~filling;
            mode_left = $urandom_range(24, 72);
         end
         mode_left--;
         ins_pct = filling ? 60 : 25;
         pick = $urandom_range(99);
         case ($urandom_range(9))
            0:       ts = '0;
            1:       ts = '1;
            2, 3:    ts = $urandom();
            default: ts = srq_pkg::STAMP_BITS'($urandom_range(15));
         endcase
         if (pick < 4) begin
            queue_request(OP_UNUSED, srq_pkg::ID_BITS'($urandom_range(255)), $urandom(),
                          1'($urandom_range(1)));
         end else begin
            if (pick < 4 + ins_pct) begin
               id = ($urandom_range(3) == 0) ? srq_pkg::ID_BITS'($urandom_range(255)) :
                                               srq_pkg::ID_BITS'($urandom_range(7));
               queue_request(srq_pkg::OP_INSERT, id, ts, 1'($urandom_range(1)));
            end else begin
               if (held_ids.size() > 0 && $urandom_range(4) != 0)
                  id = held_ids[$urandom_range(held_ids.size() - 1)];
               else
                  id = srq_pkg::ID_BITS'($urandom_range(255));
               queue_request(($urandom_range(1) == 0) ? srq_pkg::OP_REMOVE :
                                                        srq_pkg::OP_LOOKUP, id, ts,
                             1'($urandom_range(1)));
            end
            n++;
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid)
         @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_queue_op(sent_req);
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               sent_req = pending_reqs.pop_front();
               req_opcode     <= sent_req.opcode;
               req_process_id <= sent_req.process_id;
               req_timestamp  <= sent_req.timestamp;
               req_going_up   <= sent_req.going_up;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // monitor
   always @(posedge clock) begin
      srq_rsp_type got;
      srq_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status          = rsp_status;
         got.position        = rsp_position;
         got.found_timestamp = rsp_found_timestamp;
         got.found_going_up  = rsp_found_going_up;
         got.entry_count     = rsp_entry_count;
         if (expected_rsps.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: st=%0d pos=%0d ts=%h dir=%0d cnt=%0d",
                        got.status, got.position, got.found_timestamp,
                        got.found_going_up, got.entry_count);
         end else begin
            want = expected_rsps.pop_front();
            if (got.status !== want.status || got.position !== want.position ||
                got.found_timestamp !== want.found_timestamp ||
                got.found_going_up !== want.found_going_up ||
                got.entry_count !== want.entry_count) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"mismatch: exp st=%0d pos=%0d ts=%h dir=%0d cnt=%0d,",
                            " got st=%0d pos=%0d ts=%h dir=%0d cnt=%0d"},
                           want.status, want.position, want.found_timestamp,
                           want.found_going_up, want.entry_count,
                           got.status, got.position, got.found_timestamp,
                           got.found_going_up, got.entry_count);
            end
         end
      end
   end

   initial begin
      int k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue, unused opcode, extremes, ties, duplicates, absent ids, full queue
      queue_request(srq_pkg::OP_LOOKUP, 8'd5, '0, 1'b0);
      queue_request(srq_pkg::OP_REMOVE, 8'd5, '0, 1'b0);
      queue_request(OP_UNUSED, 8'hFF, '1, 1'b1);
      queue_request(srq_pkg::OP_INSERT, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      queue_request(srq_pkg::OP_INSERT, 8'h00, 32'h0, 1'b0);
      queue_request(srq_pkg::OP_INSERT, 8'd7, 32'd100, 1'b0);
      queue_request(srq_pkg::OP_INSERT, 8'd3, 32'd100, 1'b1);
      queue_request(srq_pkg::OP_INSERT, 8'd7, 32'd100, 1'b1);
      queue_request(srq_pkg::OP_LOOKUP, 8'd7, '0, 1'b0);
      queue_request(srq_pkg::OP_LOOKUP, 8'd200, '0, 1'b0);
      queue_request(srq_pkg::OP_REMOVE, 8'd200, '0, 1'b0);
      queue_request(srq_pkg::OP_REMOVE, 8'd7, '0, 1'b0);
      queue_request(srq_pkg::OP_LOOKUP, 8'd7, '0, 1'b0);
      for (k = 0; k < 12; k++)
         queue_request(srq_pkg::OP_INSERT, srq_pkg::ID_BITS'(20 + k),
                       srq_pkg::STAMP_BITS'(90 - k), k[0]);
      queue_request(srq_pkg::OP_INSERT, 8'd99, 32'd50, 1'b1);
      queue_request(srq_pkg::OP_LOOKUP, 8'hFF, '0, 1'b0);
      queue_request(srq_pkg::OP_REMOVE, 8'hFF, '0, 1'b0);

      random_phase(PHASE_ITEMS);
      wait_drained();
      send_idle_pct = 88;
      recv_idle_pct = 14;
      random_phase(PHASE_ITEMS);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(PHASE_ITEMS);
      wait_drained();
      repeat (10) @(posedge clock);

      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/srq_pkg.sv
hw/rtl/srq_ctrl.sv
hw/rtl/srq_datapath.sv
hw/rtl/sorted_request_queue.sv
hw/rtl/srq_checker.sv
bench/tb_sorted_request_queue.sv
